// File: design/csm_pkg.sv
// Package: shared constants, codes and the request token for the segment tier tracker.
package csm_pkg;

    localparam int NUM_SEG   = 8;
    localparam int COUNT_W   = 16;
    localparam int TICK_W    = 32;
    localparam int SECTOR_W  = 4;
    localparam int AGE_W     = 32;
    localparam int LIMIT_W   = 16;
    localparam int MOVED_W   = 4;
    localparam int CMP_W     = (TICK_W > AGE_W) ? TICK_W : AGE_W;
    localparam int CNT_CMP_W = (COUNT_W > LIMIT_W) ? COUNT_W : LIMIT_W;
    localparam int IN_DATA_W = ((SECTOR_W + AGE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 + MOVED_W + 7) / 8) * 8;

    localparam logic [LIMIT_W-1:0] COLD_LIMIT_RST = LIMIT_W'(5);
    localparam logic [MOVED_W-1:0] MOVED_MAX      = {MOVED_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};

    typedef enum logic
    {
        OP_ACCESS  = 1'b0,
        OP_MIGRATE = 1'b1
    } op_t;

    typedef enum logic
    {
        ST_OK    = 1'b0,
        ST_RANGE = 1'b1
    } status_t;

    typedef struct packed
    {
        logic                vld;
        op_t                 op;
        logic                err;
        logic [SECTOR_W-1:0] sector;
        logic [AGE_W-1:0]    age_limit;
        logic [TICK_W-1:0]   tick;
        logic                tier;
        logic [MOVED_W-1:0]  moved;
    } token_t;

endpackage

// File: design/csm_cell.sv
// One segment cell: holds a segment's count, last tick and tier, and steps the request along.
module csm_cell
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic [csm_pkg::SECTOR_W-1:0] seg_id,
    input  logic [csm_pkg::LIMIT_W-1:0]  cold_limit,
    input  csm_pkg::token_t              tok_in,
    output csm_pkg::token_t              tok_out
);
    import csm_pkg::*;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TICK_W-1:0]  last_reg, last_next;
    logic               tier_reg, tier_next;
    token_t             tok_reg, tok_next;

    logic               hit;
    logic               mig;
    logic [TICK_W-1:0]  age;

    always_comb
    begin
        hit = tok_in.vld && !tok_in.err && (tok_in.op == OP_ACCESS) && (tok_in.sector == seg_id);
        age = tok_in.tick - last_reg;
        mig = tok_in.vld && (tok_in.op == OP_MIGRATE) && !tier_reg
              && (CMP_W'(age) > CMP_W'(tok_in.age_limit))
              && (CNT_CMP_W'(count_reg) < CNT_CMP_W'(cold_limit));

        count_next = count_reg;
        last_next  = last_reg;
        tier_next  = tier_reg;
        tok_next   = tok_in;

        if (hit)
        begin
            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + COUNT_W'(1);
            end
            last_next     = tok_in.tick;
            tok_next.tier = tier_reg;
        end

        if (mig)
        begin
            tier_next = 1'b1;
            if (tok_in.moved != MOVED_MAX)
            begin
                tok_next.moved = tok_in.moved + MOVED_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            last_reg    <= '0;
            tier_reg    <= 1'b0;
            tok_reg.vld <= 1'b0;
        end
        else if (adv)
        begin
            count_reg <= count_next;
            last_reg  <= last_next;
            tier_reg  <= tier_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

    // a slow segment never returns to the fast tier
    assert property (@(posedge clk) disable iff (!rst_n) tier_reg |=> tier_reg)
        else $error("segment tier returned to fast");

endmodule

// File: design/cold_segment_tier_migration.sv
// Top level: segment tier tracker built as a row of segment cells with an output register.
// Each request walks the row of NUM_SEG cells, one cell per cycle while the row advances,
// and lands in the output register. The row is a pipeline: a new request is taken every
// cycle while the output register is empty or being drained, and the whole row holds while
// a result waits. An access bumps the tick on entry; a migration sweep collects its moved
// count as it passes each cell. cold_access_limit resets to 5 and is written through cfg_we /
// cfg_wdata; it is to be written only while idle, which the block itself does not enforce.
module cold_segment_tier_migration
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [csm_pkg::LIMIT_W-1:0]    cfg_wdata,     // cold_access_limit
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [csm_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // sector, age_limit, zero pad
    input  logic                           s_axis_tuser,  // opcode
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [csm_pkg::OUT_DATA_W-1:0] m_axis_tdata   // status, tier, moved_count, zero pad
);
    import csm_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic               out_vld_reg, out_vld_next;
    logic               out_status_reg, out_tier_reg;
    logic [MOVED_W-1:0] out_moved_reg;

    logic               adv;
    logic               acc;
    logic               in_err;
    logic [SECTOR_W-1:0] in_sector;
    op_t                in_op;
    token_t             tok [NUM_SEG+1];

    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign acc           = s_axis_tvalid && adv;
    assign in_sector     = s_axis_tdata[SECTOR_W-1:0];
    assign in_op         = op_t'(s_axis_tuser);
    assign in_err        = (in_op == OP_ACCESS)
                           && ({1'b0, in_sector} >= (SECTOR_W+1)'(NUM_SEG));

    always_comb
    begin
        tick_next = tick_reg;
        if (acc && (in_op == OP_ACCESS) && !in_err)
        begin
            tick_next = tick_reg + TICK_W'(1);
        end

        tok[0].vld       = s_axis_tvalid;
        tok[0].op        = in_op;
        tok[0].err       = in_err;
        tok[0].sector    = in_sector;
        tok[0].age_limit = s_axis_tdata[SECTOR_W +: AGE_W];
        tok[0].tick      = tick_next;
        tok[0].tier      = 1'b0;
        tok[0].moved     = '0;

        out_vld_next = out_vld_reg;
        if (adv)
        begin
            out_vld_next = tok[NUM_SEG].vld;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_SEG; gi++)
        begin : g_cell
            csm_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .adv        (adv),
                .seg_id     (SECTOR_W'(gi)),
                .cold_limit (limit_reg),
                .tok_in     (tok[gi]),
                .tok_out    (tok[gi+1])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= COLD_LIMIT_RST;
            tick_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            tick_reg    <= tick_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_status_reg <= tok[NUM_SEG].err ? ST_RANGE : ST_OK;
            out_tier_reg   <= tok[NUM_SEG].tier;
            out_moved_reg  <= tok[NUM_SEG].moved;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-2-MOVED_W){1'b0}}, out_moved_reg,
                            out_tier_reg, out_status_reg};

    // an out-of-range request reports nothing else
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && (out_status_reg == ST_RANGE)) |-> (!out_tier_reg && (out_moved_reg == '0)))
        else $error("error result carries tier or moved count");

    // the tick only moves on an accepted in-range access
    assert property (@(posedge clk) disable iff (!rst_n)
        !(acc && (in_op == OP_ACCESS) && !in_err) |=> $stable(tick_reg))
        else $error("tick moved without an access");

    // a held result is not overwritten by the row
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !m_axis_tready) |=> (out_vld_reg && $stable(m_axis_tdata)))
        else $error("pending result changed under stall");

    // a migration result never reports a tier
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && tok[NUM_SEG].vld && (tok[NUM_SEG].op == OP_MIGRATE)) |=> !out_tier_reg)
        else $error("sweep result carries a tier");

endmodule
